@@ hdl/ssuid_pkg.sv @@
// Shared types and codes for the small set union / intersect / difference block.
package ssuid_pkg;

   // Fixed field widths of the channels
   localparam int OP_W    = 3;
   localparam int VALUE_W = 32;

   // Operation codes on the request channel
   localparam logic [OP_W-1:0] OP_APPEND_A = 3'd0;
   localparam logic [OP_W-1:0] OP_APPEND_B = 3'd1;
   localparam logic [OP_W-1:0] OP_CLEAR_A  = 3'd2;
   localparam logic [OP_W-1:0] OP_CLEAR_B  = 3'd3;
   localparam logic [OP_W-1:0] OP_UNION    = 3'd4;
   localparam logic [OP_W-1:0] OP_INTERSECT = 3'd5;
   localparam logic [OP_W-1:0] OP_DIFF     = 3'd6;

   // Status codes on the response channel
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   // Command class handed from the front end to the back end
   typedef enum logic [2:0] {
      KIND_APPEND,
      KIND_CLEAR,
      KIND_UNION,
      KIND_INTERSECT,
      KIND_DIFF,
      KIND_NOP
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic     sel_b;   // store B for append / clear
   } cmd_type;

endpackage

@@ hdl/ssuid_chan_if.sv @@
// Valid/ready channel interfaces for the request and response beats.
interface ssuid_req_if;
   import ssuid_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [OP_W-1:0]            operation;
   logic signed [VALUE_W-1:0]  value;

   modport source (output valid, output operation, output value, input ready);
   modport sink   (input valid, input operation, input value, output ready);
endinterface

interface ssuid_rsp_if;
   import ssuid_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [VALUE_W-1:0]  result_value;
   logic                       last;
   logic                       empty_res;
   logic                       status;

   modport source (output valid, output result_value, output last, output empty_res,
                   output status, input ready);
   modport sink   (input valid, input result_value, input last, input empty_res,
                   input status, output ready);
endinterface

@@ hdl/ssuid_front.sv @@
// Front end: accepts request beats, classifies them and queues commands.
module ssuid_front #(
   parameter int WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   ssuid_req_if.sink          req_ch,
   output logic               q_valid,
   output ssuid_pkg::cmd_type q_cmd,
   output logic [WIDTH-1:0]   q_value,
   input  logic               q_pop
);
   import ssuid_pkg::*;

   localparam int XW     = (WIDTH > VALUE_W) ? WIDTH : VALUE_W;
   localparam int QDEPTH = 2;

   cmd_type          dec_cmd;
   logic [XW-1:0]    dec_wide;
   logic [WIDTH-1:0] dec_value;
   logic             push;

   cmd_type          cmd_ff [QDEPTH];
   logic [WIDTH-1:0] val_ff [QDEPTH];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       fill_ff;
   logic [1:0]       fill_in;

   // classify the operation
   always_comb begin
      dec_cmd.sel_b = 1'b0;
      case (req_ch.operation)
         OP_APPEND_A: begin
            dec_cmd.kind = KIND_APPEND;
         end
         OP_APPEND_B: begin
            dec_cmd.kind  = KIND_APPEND;
            dec_cmd.sel_b = 1'b1;
         end
         OP_CLEAR_A: begin
            dec_cmd.kind = KIND_CLEAR;
         end
         OP_CLEAR_B: begin
            dec_cmd.kind  = KIND_CLEAR;
            dec_cmd.sel_b = 1'b1;
         end
         OP_UNION:     dec_cmd.kind = KIND_UNION;
         OP_INTERSECT: dec_cmd.kind = KIND_INTERSECT;
         OP_DIFF:      dec_cmd.kind = KIND_DIFF;
         default:      dec_cmd.kind = KIND_NOP;
      endcase
   end

   // stored word is the low WIDTH bits of the zero-extended value
   assign dec_wide  = XW'($unsigned(req_ch.value));
   assign dec_value = dec_wide[WIDTH-1:0];

   assign req_ch.ready = (fill_ff != 2'(QDEPTH));
   assign push         = req_ch.valid && req_ch.ready;

   // occupancy of the command queue
   always_comb begin
      case ({push, q_pop})
         2'b10:   fill_in = fill_ff + 2'd1;
         2'b01:   fill_in = fill_ff - 2'd1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         fill_ff <= fill_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (q_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   // queue entries
   always_ff @(posedge clock) begin
      if (push) begin
         cmd_ff[wr_ptr_ff] <= dec_cmd;
         val_ff[wr_ptr_ff] <= dec_value;
      end
   end

   assign q_valid = (fill_ff != 2'd0);
   assign q_cmd   = cmd_ff[rd_ptr_ff];
   assign q_value = val_ff[rd_ptr_ff];

endmodule

@@ hdl/ssuid_back.sv @@
// Back end: holds both stores, runs appends, clears and set scans, drives responses.
module ssuid_back #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  ssuid_pkg::cmd_type q_cmd,
   input  logic [WIDTH-1:0]   q_value,
   output logic               q_pop,
   ssuid_rsp_if.source        rsp_ch
);
   import ssuid_pkg::*;

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (WIDTH > VALUE_W) ? WIDTH : VALUE_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // element stores, no reset: only entries below the counts are read
   logic [WIDTH-1:0] store_a_ff [DEPTH];
   logic [WIDTH-1:0] store_b_ff [DEPTH];
   logic             wr_a;
   logic             wr_b;

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_a_ff, count_a_in;
   logic [CW-1:0]    count_b_ff, count_b_in;
   logic [CW-1:0]    idx_ff, idx_in;
   logic             scan_b_ff, scan_b_in;
   kind_type         kind_ff, kind_in;
   logic [WIDTH-1:0] hold_ff, hold_in;
   logic             hold_valid_ff, hold_valid_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_empty_ff, rsp_empty_in;
   logic                 rsp_status_ff, rsp_status_in;

   logic             out_free;
   logic [WIDTH-1:0] scan_elem;
   logic [XW-1:0]    hold_wide;
   logic             in_a;
   logic             in_b;
   logic             in_other;
   logic             scan_end;
   logic             qualify;
   logic             full;

   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign scan_elem = scan_b_ff ? store_b_ff[idx_ff[IW-1:0]] : store_a_ff[idx_ff[IW-1:0]];
   assign hold_wide = XW'(hold_ff);
   assign scan_end  = scan_b_ff ? (idx_ff >= count_b_ff) : (idx_ff >= count_a_ff);

   // parallel membership compare of the scanned element against both stores
   always_comb begin
      in_a = 1'b0;
      in_b = 1'b0;
      for (int j = 0; j < DEPTH; j++) begin
         if ((store_a_ff[j] == scan_elem) && (CW'(j) < count_a_ff)) begin
            in_a = 1'b1;
         end
         if ((store_b_ff[j] == scan_elem) && (CW'(j) < count_b_ff)) begin
            in_b = 1'b1;
         end
      end
   end

   assign in_other = scan_b_ff ? in_a : in_b;

   // does the scanned element belong to the result
   always_comb begin
      case (kind_ff)
         KIND_UNION:     qualify = scan_b_ff ? !in_other : 1'b1;
         KIND_INTERSECT: qualify = in_other;
         KIND_DIFF:      qualify = !in_other;
         default:        qualify = 1'b0;
      endcase
   end

   assign full = q_cmd.sel_b ? (count_b_ff == CW'(DEPTH)) : (count_a_ff == CW'(DEPTH));

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_a_in    = count_a_ff;
      count_b_in    = count_b_ff;
      idx_in        = idx_ff;
      scan_b_in     = scan_b_ff;
      kind_in       = kind_ff;
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_status_in = rsp_status_ff;
      q_pop         = 1'b0;
      wr_a          = 1'b0;
      wr_b          = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid && out_free) begin
               q_pop         = 1'b1;
               // status beat unless a set scan starts
               rsp_value_in  = '0;
               rsp_last_in   = 1'b1;
               rsp_empty_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               case (q_cmd.kind)
                  KIND_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (full) begin
                        rsp_status_in = STATUS_FULL;
                     end else if (q_cmd.sel_b) begin
                        wr_b       = 1'b1;
                        count_b_in = count_b_ff + CW'(1);
                     end else begin
                        wr_a       = 1'b1;
                        count_a_in = count_a_ff + CW'(1);
                     end
                  end
                  KIND_CLEAR: begin
                     rsp_valid_in = 1'b1;
                     if (q_cmd.sel_b) begin
                        count_b_in = '0;
                     end else begin
                        count_a_in = '0;
                     end
                  end
                  KIND_UNION, KIND_INTERSECT, KIND_DIFF: begin
                     rsp_valid_in  = 1'b0;
                     kind_in       = q_cmd.kind;
                     scan_b_in     = (q_cmd.kind == KIND_INTERSECT);
                     idx_in        = '0;
                     hold_valid_in = 1'b0;
                     state_in      = ST_SCAN;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_end) begin
               if ((kind_ff == KIND_UNION) && !scan_b_ff) begin
                  scan_b_in = 1'b1;
                  idx_in    = '0;
               end else begin
                  state_in = ST_FINISH;
               end
            end else if (out_free) begin
               idx_in = idx_ff + CW'(1);
               if (qualify) begin
                  // one element of lookahead decides the last mark
                  if (hold_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_value_in  = hold_wide[VALUE_W-1:0];
                     rsp_last_in   = 1'b0;
                     rsp_empty_in  = 1'b0;
                     rsp_status_in = STATUS_OK;
                  end
                  hold_in       = scan_elem;
                  hold_valid_in = 1'b1;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_last_in   = 1'b1;
               rsp_status_in = STATUS_OK;
               if (hold_valid_ff) begin
                  rsp_value_in = hold_wide[VALUE_W-1:0];
                  rsp_empty_in = 1'b0;
               end else begin
                  rsp_value_in = '0;
                  rsp_empty_in = 1'b1;
               end
               hold_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_a_ff    <= '0;
         count_b_ff    <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_a_ff    <= count_a_in;
         count_b_ff    <= count_b_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      scan_b_ff     <= scan_b_in;
      kind_ff       <= kind_in;
      hold_ff       <= hold_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_status_ff <= rsp_status_in;
   end

   // store writes at the current fill position
   always_ff @(posedge clock) begin
      if (wr_a) begin
         store_a_ff[count_a_ff[IW-1:0]] <= q_value;
      end
      if (wr_b) begin
         store_b_ff[count_b_ff[IW-1:0]] <= q_value;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.result_value = rsp_value_ff;
   assign rsp_ch.last         = rsp_last_ff;
   assign rsp_ch.empty_res    = rsp_empty_ff;
   assign rsp_ch.status       = rsp_status_ff;

endmodule

@@ hdl/small_set_union_intersect_diff.sv @@
// Top level of the two-store set union / intersect / difference block.
//
//   channel   dir   handshake       beat contents
//   req_ch    in    valid / ready   operation, value
//   rsp_ch    out   valid / ready   result_value, last, empty_res, status
//
// Append, clear and unused codes: one status beat each.
// Union, intersect and difference: element beats, the final one marked last.
// Each scan step reads one element and compares it against every entry of the other store.
// Reset clears both counts; the stores are not cleared and need no clearing pass.
// A two-entry command queue and an output register let requests and responses stall apart.
module small_set_union_intersect_diff #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   ssuid_req_if.sink   req_ch,
   ssuid_rsp_if.source rsp_ch
);
   import ssuid_pkg::*;

   logic             q_valid;
   cmd_type          q_cmd;
   logic [WIDTH-1:0] q_value;
   logic             q_pop;

   ssuid_front #(
      .WIDTH (WIDTH)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_valid (q_valid),
      .q_cmd   (q_cmd),
      .q_value (q_value),
      .q_pop   (q_pop)
   );

   ssuid_back #(
      .DEPTH (DEPTH),
      .WIDTH (WIDTH)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_cmd   (q_cmd),
      .q_value (q_value),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

@@ hdl/ssuid_checker.sv @@
// Port-level assertions for the set block, bound onto the top level.
module ssuid_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_value,
   input logic        rsp_last,
   input logic        rsp_empty,
   input logic        rsp_status
);

   // no response beat right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_last))
      else $error("stalled response changed");

   // a refused append is a lone status beat
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_empty && rsp_last)
      else $error("full status beat malformed");

   // a beat without an element carries zero and closes its request
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty |-> rsp_last && (rsp_value == 32'd0))
      else $error("empty beat malformed");

   // element beats never carry an error
   a_elem_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_empty |-> !rsp_status)
      else $error("element beat with error status");

endmodule

bind small_set_union_intersect_diff ssuid_checker u_ssuid_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_value  (rsp_ch.result_value),
   .rsp_last   (rsp_ch.last),
   .rsp_empty  (rsp_ch.empty_res),
   .rsp_status (rsp_ch.status)
);
